>>> rtl/sector_lease_lock_table_core_defines.svh
// Assertion macros shared by the lock table checker.
`ifndef SECTOR_LEASE_LOCK_TABLE_CORE_DEFINES_SVH
`define SECTOR_LEASE_LOCK_TABLE_CORE_DEFINES_SVH

// Same-cycle implication, sampled on i_clk and disabled while i_rst_n is low.
`define SLLT_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sllt: same-cycle property failed");

// Next-cycle implication, sampled on i_clk and disabled while i_rst_n is low.
`define SLLT_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sllt: next-cycle property failed");

`endif

>>> rtl/sllt_pkg.sv
// Types, constants and codes of the sector lease lock table.
package sllt_pkg;

    localparam int TABLE_ENTRIES = 16;
    localparam int TE_IW         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int TE_CW         = $clog2(TABLE_ENTRIES + 1);

    localparam logic [15:0] AGE_SAT       = 16'hFFFF;
    localparam logic [15:0] MAX_AGE_RESET = 16'd30;

    typedef enum logic [2:0] {
        REQ_ACQUIRE = 3'd0,
        REQ_RELEASE = 3'd1,
        REQ_DIRTY   = 3'd2,
        REQ_BUMP    = 3'd3,
        REQ_QUERY   = 3'd4,
        REQ_TICK    = 3'd5,
        REQ_SWEEP   = 3'd6,
        REQ_CLEAR   = 3'd7
    } t_req_type;

    typedef enum logic [1:0] {
        STAT_OK     = 2'd0,
        STAT_LOCKED = 2'd1,
        STAT_FULL   = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_UPDATE,
        S_RESP
    } t_state;

    typedef struct packed {
        t_req_type   req_type;
        logic [15:0] client_id;
        logic [15:0] sector_x;
        logic [15:0] sector_y;
    } t_req;

    typedef struct packed {
        logic [15:0] sector_x;
        logic [15:0] sector_y;
        logic [15:0] owner;
        logic        dirty;
        logic [31:0] version;
        logic [15:0] age;
    } t_entry;

    typedef struct packed {
        logic             en;
        logic [TE_IW-1:0] addr;
    } t_mem_rd;

    typedef struct packed {
        logic             en;
        logic [TE_IW-1:0] addr;
        t_entry           data;
    } t_mem_wr;

    typedef struct packed {
        logic        granted;
        logic [15:0] owner;
        logic        holds_lock;
        logic        dirty;
        logic [31:0] version;
        t_status     status;
    } t_result;

endpackage

>>> rtl/sllt_if.sv
// Handshake channels of the lock table: requests, results and configuration.
interface sllt_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  req_type;
    logic [15:0] client_id;
    logic [15:0] sector_x;
    logic [15:0] sector_y;

    modport source (output valid, req_type, client_id, sector_x, sector_y, input ready);
    modport sink   (input valid, req_type, client_id, sector_x, sector_y, output ready);
endinterface

interface sllt_rsp_if;
    logic        valid;
    logic        ready;
    logic        granted;
    logic [15:0] owner;
    logic        holds_lock;
    logic        dirty;
    logic [31:0] version;
    logic [1:0]  status;

    modport source (output valid, granted, owner, holds_lock, dirty, version, status,
                    input ready);
    modport sink   (input valid, granted, owner, holds_lock, dirty, version, status,
                    output ready);
endinterface

interface sllt_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

>>> rtl/sllt_entry_ram.sv
// Entry storage of the lock table: one write port, one registered read port.
module sllt_entry_ram (
    input  logic            i_clk,
    input  sllt_pkg::t_mem_rd i_rd,
    input  sllt_pkg::t_mem_wr i_wr,
    output sllt_pkg::t_entry  o_rd_data
);
    import sllt_pkg::*;

    t_entry r_mem [TABLE_ENTRIES];
    t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        if (i_rd.en) begin
            r_rd_data <= r_mem[i_rd.addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> rtl/sllt_ctrl.sv
// Sequencer of the lock table: entry scan, read-modify-write and valid bits.
module sllt_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_req_vld,
    input  sllt_pkg::t_req    i_req,
    output logic              o_req_rdy,
    input  logic [15:0]       i_max_age,
    output sllt_pkg::t_mem_rd o_rd,
    input  sllt_pkg::t_entry  i_rd_data,
    output sllt_pkg::t_mem_wr o_wr,
    input  logic              i_out_free,
    output logic              o_res_vld,
    output sllt_pkg::t_result o_res
);
    import sllt_pkg::*;

    t_state             r_state, n_state;
    t_req               r_req;
    logic [TE_CW-1:0]   r_rd_cnt;
    logic               r_chk_vld;
    logic [TE_IW-1:0]   r_chk_idx;
    logic               r_hit;
    logic [TE_IW-1:0]   r_hit_idx;
    t_entry             r_ent;
    logic               r_free_fnd;
    logic [TE_IW-1:0]   r_free_idx;
    logic [TABLE_ENTRIES-1:0] r_valid;
    t_result            r_res;

    logic    accept;
    logic    is_find;
    logic    key_hit;
    logic    last_chk;
    logic    scan_done;
    logic    own_match;
    t_entry  new_ent;
    t_entry  rep_ent;
    logic    rep;
    logic    upd_granted;
    t_status upd_status;
    logic    set_vld;
    logic    clr_vld;
    t_mem_wr upd_wr;
    t_result upd_res;
    t_result start_res;

    assign accept   = (r_state == S_IDLE) && i_req_vld;
    assign is_find  = (r_req.req_type != REQ_TICK) && (r_req.req_type != REQ_SWEEP);
    assign key_hit  = r_chk_vld && r_valid[r_chk_idx]
                      && (i_rd_data.sector_x == r_req.sector_x)
                      && (i_rd_data.sector_y == r_req.sector_y);
    assign last_chk = r_chk_vld && (r_chk_idx == TE_IW'(TABLE_ENTRIES - 1));
    assign scan_done = last_chk || (is_find && key_hit);

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_req_vld) begin
                    n_state = (i_req.req_type == REQ_CLEAR) ? S_RESP : S_SCAN;
                end
            end
            S_SCAN: begin
                if (scan_done) begin
                    n_state = is_find ? S_UPDATE : S_RESP;
                end
            end
            S_UPDATE: n_state = S_RESP;
            S_RESP: begin
                if (i_out_free) begin
                    n_state = S_IDLE;
                end
            end
        endcase
    end

    // The read pointer runs one entry ahead of the compare, so the scan
    // covers one entry per cycle.
    always_comb begin
        o_req_rdy = (r_state == S_IDLE);
        o_res_vld = (r_state == S_RESP) && i_out_free;
        o_res     = r_res;
        o_rd.en   = (r_state == S_SCAN) && (r_rd_cnt != TE_CW'(TABLE_ENTRIES));
        o_rd.addr = r_rd_cnt[TE_IW-1:0];
    end

    // Tick, sweep and clear answer with granted set and every other field zero.
    always_comb begin
        start_res         = '0;
        start_res.granted = 1'b1;
    end

    // Result and write-back of the lookup operations.
    always_comb begin
        own_match = (r_ent.owner == r_req.client_id);

        new_ent          = '0;
        new_ent.sector_x = r_req.sector_x;
        new_ent.sector_y = r_req.sector_y;
        new_ent.owner    = (r_req.req_type == REQ_ACQUIRE) ? r_req.client_id : 16'd0;
        new_ent.version  = 32'd1;

        upd_wr      = '0;
        upd_wr.addr = r_hit_idx;
        upd_wr.data = r_ent;
        rep         = 1'b0;
        rep_ent     = r_ent;
        upd_granted = 1'b0;
        upd_status  = STAT_OK;
        set_vld     = 1'b0;
        clr_vld     = 1'b0;

        unique case (r_req.req_type)
            REQ_ACQUIRE, REQ_BUMP: begin
                if (r_hit) begin
                    if (r_req.req_type == REQ_BUMP) begin
                        upd_wr.en           = 1'b1;
                        upd_wr.data.version = r_ent.version + 32'd1;
                        rep_ent             = upd_wr.data;
                        rep                 = 1'b1;
                        upd_granted         = 1'b1;
                    end else if (own_match) begin
                        upd_wr.en       = 1'b1;
                        upd_wr.data.age = 16'd0;
                        rep             = 1'b1;
                        upd_granted     = 1'b1;
                    end else begin
                        rep        = 1'b1;
                        upd_status = STAT_LOCKED;
                    end
                end else if (r_free_fnd) begin
                    upd_wr.en   = 1'b1;
                    upd_wr.addr = r_free_idx;
                    upd_wr.data = new_ent;
                    set_vld     = 1'b1;
                    rep         = 1'b1;
                    rep_ent     = new_ent;
                    upd_granted = 1'b1;
                end else begin
                    upd_status = STAT_FULL;
                end
            end
            REQ_RELEASE: begin
                if (r_hit) begin
                    if (own_match) begin
                        clr_vld     = 1'b1;
                        upd_granted = 1'b1;
                    end else begin
                        rep        = 1'b1;
                        upd_status = STAT_LOCKED;
                    end
                end
            end
            REQ_DIRTY: begin
                if (r_hit) begin
                    upd_wr.en         = 1'b1;
                    upd_wr.data.dirty = 1'b1;
                    rep_ent           = upd_wr.data;
                    rep               = 1'b1;
                    upd_granted       = 1'b1;
                end
            end
            REQ_QUERY: begin
                rep         = r_hit;
                upd_granted = r_hit;
            end
            REQ_TICK, REQ_SWEEP, REQ_CLEAR: begin
                rep = 1'b0;
            end
        endcase

        upd_res.granted    = upd_granted;
        upd_res.owner      = rep ? rep_ent.owner : 16'd0;
        upd_res.holds_lock = rep && (rep_ent.owner == r_req.client_id);
        upd_res.dirty      = rep && rep_ent.dirty;
        upd_res.version    = rep ? rep_ent.version : 32'd0;
        upd_res.status     = upd_status;
    end

    // Write port: tick ages the entry under compare, lookups write in the
    // update cycle. The scan reads the next entry while writing the current
    // one, and the next request reads only after the update is done.
    always_comb begin
        o_wr = '0;
        if (r_state == S_UPDATE) begin
            o_wr = upd_wr;
        end else if ((r_state == S_SCAN) && (r_req.req_type == REQ_TICK)) begin
            o_wr.en       = r_chk_vld && r_valid[r_chk_idx] && (i_rd_data.age != AGE_SAT);
            o_wr.addr     = r_chk_idx;
            o_wr.data     = i_rd_data;
            o_wr.data.age = i_rd_data.age + 16'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_rd_cnt   <= '0;
            r_chk_vld  <= 1'b0;
            r_hit      <= 1'b0;
            r_free_fnd <= 1'b0;
            r_valid    <= '0;
        end else begin
            r_state <= n_state;
            if (accept) begin
                r_rd_cnt   <= '0;
                r_chk_vld  <= 1'b0;
                r_hit      <= 1'b0;
                r_free_fnd <= 1'b0;
                if (i_req.req_type == REQ_CLEAR) begin
                    r_valid <= '0;
                end
            end
            if (r_state == S_SCAN) begin
                r_chk_vld <= o_rd.en;
                if (o_rd.en) begin
                    r_rd_cnt <= r_rd_cnt + TE_CW'(1);
                end
                if (is_find && key_hit) begin
                    r_hit <= 1'b1;
                end
                if (r_chk_vld && !r_valid[r_chk_idx] && !r_free_fnd) begin
                    r_free_fnd <= 1'b1;
                end
                if ((r_req.req_type == REQ_SWEEP) && r_chk_vld && r_valid[r_chk_idx]
                        && (i_rd_data.age > i_max_age)) begin
                    r_valid[r_chk_idx] <= 1'b0;
                end
            end
            if (r_state == S_UPDATE) begin
                if (set_vld) begin
                    r_valid[r_free_idx] <= 1'b1;
                end
                if (clr_vld) begin
                    r_valid[r_hit_idx] <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req <= i_req;
            r_res <= start_res;
        end
        if (r_state == S_SCAN) begin
            r_chk_idx <= o_rd.addr;
            if (key_hit) begin
                r_hit_idx <= r_chk_idx;
                r_ent     <= i_rd_data;
            end
            if (r_chk_vld && !r_valid[r_chk_idx] && !r_free_fnd) begin
                r_free_idx <= r_chk_idx;
            end
        end
        if (r_state == S_UPDATE) begin
            r_res <= upd_res;
        end
    end

endmodule

>>> rtl/sector_lease_lock_table_core.sv
// Top level of the sector lease lock table.
//
//  channel  | dir | handshake      | carries
//  ---------+-----+----------------+---------------------------------------------
//  i_req    | in  | valid / ready  | req_type, client_id, sector_x, sector_y
//  o_rsp    | out | valid / ready  | granted, owner, holds_lock, dirty, version,
//           |     |                | status
//  i_cfg    | in  | valid / ready  | max_age (ready is always high)
//
// A lookup scans the entries in order; it ends early when the key is hit.
// Tick and sweep walk every entry; clear goes straight to the result.
// The entry memory's single read port, one entry per cycle, paces the scan.
// Synchronous reset empties the table and sets max_age to 30.
// A stalled result sits in the output register while the next request runs.
module sector_lease_lock_table_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sllt_req_if.sink    i_req,
    sllt_rsp_if.source  o_rsp,
    sllt_cfg_if.sink    i_cfg
);
    import sllt_pkg::*;

    logic [15:0] r_max_age;
    logic        r_out_vld;
    t_result     r_out;

    t_req    req;
    logic    out_free;
    logic    res_vld;
    t_result res;
    t_mem_rd mem_rd;
    t_mem_wr mem_wr;
    t_entry  mem_q;
    logic    req_rdy;

    assign req.req_type  = t_req_type'(i_req.req_type);
    assign req.client_id = i_req.client_id;
    assign req.sector_x  = i_req.sector_x;
    assign req.sector_y  = i_req.sector_y;
    assign i_req.ready   = req_rdy;

    assign out_free = !r_out_vld || o_rsp.ready;

    sllt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req_vld  (i_req.valid),
        .i_req      (req),
        .o_req_rdy  (req_rdy),
        .i_max_age  (r_max_age),
        .o_rd       (mem_rd),
        .i_rd_data  (mem_q),
        .o_wr       (mem_wr),
        .i_out_free (out_free),
        .o_res_vld  (res_vld),
        .o_res      (res)
    );

    sllt_entry_ram u_ram (
        .i_clk     (i_clk),
        .i_rd      (mem_rd),
        .i_wr      (mem_wr),
        .o_rd_data (mem_q)
    );

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_age <= MAX_AGE_RESET;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                r_max_age <= i_cfg.data;
            end
            if (res_vld) begin
                r_out_vld <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_vld) begin
            r_out <= res;
        end
    end

    assign o_rsp.valid      = r_out_vld;
    assign o_rsp.granted    = r_out.granted;
    assign o_rsp.owner      = r_out.owner;
    assign o_rsp.holds_lock = r_out.holds_lock;
    assign o_rsp.dirty      = r_out.dirty;
    assign o_rsp.version    = r_out.version;
    assign o_rsp.status     = r_out.status;

endmodule

>>> rtl/sllt_checker.sv
// Port-level checks of the lock table, bound to the top level.
`include "sector_lease_lock_table_core_defines.svh"

module sllt_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_req_valid,
    input logic        i_req_ready,
    input logic        i_rsp_valid,
    input logic        i_rsp_ready,
    input logic        i_rsp_granted,
    input logic [15:0] i_rsp_owner,
    input logic        i_rsp_holds_lock,
    input logic        i_rsp_dirty,
    input logic [31:0] i_rsp_version,
    input logic [1:0]  i_rsp_status
);
    import sllt_pkg::*;

    // A stalled result stays valid and keeps its version, owner and status.
    `SLLT_ASSERT_NXT(a_rsp_hold, i_rsp_valid && !i_rsp_ready, i_rsp_valid && $stable(i_rsp_version) && $stable(i_rsp_owner) && $stable(i_rsp_status))

    // The table works on one request at a time.
    `SLLT_ASSERT_NXT(a_busy_after_accept, i_req_valid && i_req_ready, !i_req_ready)

    // A refused request never reports the lock as held.
    `SLLT_ASSERT_IMP(a_refused_not_held, i_rsp_valid && (i_rsp_status != STAT_OK), !i_rsp_granted && !i_rsp_holds_lock)

    // A full table reports no entry.
    `SLLT_ASSERT_IMP(a_full_no_entry, i_rsp_valid && (i_rsp_status == STAT_FULL), (i_rsp_owner == 16'd0) && (i_rsp_version == 32'd0) && !i_rsp_dirty)

endmodule

bind sector_lease_lock_table_core sllt_checker u_sllt_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_req_valid      (i_req.valid),
    .i_req_ready      (i_req.ready),
    .i_rsp_valid      (o_rsp.valid),
    .i_rsp_ready      (o_rsp.ready),
    .i_rsp_granted    (o_rsp.granted),
    .i_rsp_owner      (o_rsp.owner),
    .i_rsp_holds_lock (o_rsp.holds_lock),
    .i_rsp_dirty      (o_rsp.dirty),
    .i_rsp_version    (o_rsp.version),
    .i_rsp_status     (o_rsp.status)
);

>>> tb/sector_lease_lock_table_core_tb.sv
// Self-checking testbench for the sector lease lock table with directed and random requests.
module sector_lease_lock_table_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sllt_pkg::*;

    localparam int CYCLE_LIMIT   = 400_000;
    localparam int RANDOM_PHASES = 6;
    localparam int PHASE_ITEMS   = 285;
    localparam int KEY_POOL      = 24;
    localparam int CLIENT_POOL   = 6;

    logic i_clk = 1'b0;
    logic i_rst_n;

    sllt_req_if req_if ();
    sllt_rsp_if rsp_if ();
    sllt_cfg_if cfg_if ();

    sector_lease_lock_table_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if),
        .i_cfg   (cfg_if)
    );

    // Shadow copy of the lock table and of max_age.
    logic        lease_valid [TABLE_ENTRIES];
    logic [15:0] lease_x     [TABLE_ENTRIES];
    logic [15:0] lease_y     [TABLE_ENTRIES];
    logic [15:0] lease_owner [TABLE_ENTRIES];
    logic        lease_dirty [TABLE_ENTRIES];
    logic [31:0] lease_ver   [TABLE_ENTRIES];
    logic [15:0] lease_age   [TABLE_ENTRIES];
    logic [15:0] age_limit;

    logic [15:0] pool_x      [KEY_POOL];
    logic [15:0] pool_y      [KEY_POOL];
    logic [15:0] pool_client [CLIENT_POOL];

    t_req    pending_reqs[$];
    t_result expected_results[$];
    t_req    drive_item;
    t_result oldest_result;

    int   req_gap       = 0;
    int   rsp_stall     = 0;
    logic req_taken     = 1'b0;
    logic rsp_taken     = 1'b0;
    bit   quiet         = 1'b0;
    int   fail_count    = 0;
    int   cycle_count   = 0;
    int   req_count     = 0;
    int   granted_count = 0;
    int   locked_count  = 0;
    int   full_count    = 0;
    int   setting_count = 0;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic void claim_slot(input int slot, input t_req rq, input logic [15:0] who);
        lease_valid[slot] = 1'b1;
        lease_x[slot]     = rq.sector_x;
        lease_y[slot]     = rq.sector_y;
        lease_owner[slot] = who;
        lease_dirty[slot] = 1'b0;
        lease_ver[slot]   = 32'd1;
        lease_age[slot]   = 16'd0;
    endfunction

    // Applies one request to the shadow table and returns the result it must produce.
    function automatic t_result lease_table_apply(input t_req rq);
        t_result r;
        int      hit;
        int      slot;
        int      i;
        r = '0;
        r.status = STAT_OK;
        hit = -1;
        slot = -1;
        // Scanning downward leaves the lowest matching and the lowest free index.
        for (i = TABLE_ENTRIES - 1; i >= 0; i--) begin
            if (lease_valid[i] && lease_x[i] == rq.sector_x && lease_y[i] == rq.sector_y)
                hit = i;
            if (!lease_valid[i])
                slot = i;
        end
        case (rq.req_type)
            REQ_ACQUIRE: begin
                if (hit >= 0) begin
                    if (lease_owner[hit] == rq.client_id) begin
                        lease_age[hit] = 16'd0;
                        r.granted = 1'b1;
                    end else begin
                        r.status = STAT_LOCKED;
                    end
                end else if (slot >= 0) begin
                    claim_slot(slot, rq, rq.client_id);
                    hit = slot;
                    r.granted = 1'b1;
                end else begin
                    r.status = STAT_FULL;
                end
            end
            REQ_RELEASE: begin
                if (hit >= 0) begin
                    if (lease_owner[hit] == rq.client_id) begin
                        lease_valid[hit] = 1'b0;
                        r.granted = 1'b1;
                        hit = -1;
                    end else begin
                        r.status = STAT_LOCKED;
                    end
                end
            end
            REQ_DIRTY: begin
                if (hit >= 0) begin
                    lease_dirty[hit] = 1'b1;
                    r.granted = 1'b1;
                end
            end
            REQ_BUMP: begin
                if (hit >= 0) begin
                    lease_ver[hit] = lease_ver[hit] + 32'd1;
                    r.granted = 1'b1;
                end else if (slot >= 0) begin
                    claim_slot(slot, rq, 16'd0);
                    hit = slot;
                    r.granted = 1'b1;
                end else begin
                    r.status = STAT_FULL;
                end
            end
            REQ_QUERY: begin
                if (hit >= 0)
                    r.granted = 1'b1;
            end
            REQ_TICK: begin
                for (i = 0; i < TABLE_ENTRIES; i++)
                    if (lease_valid[i] && lease_age[i] != AGE_SAT)
                        lease_age[i] = lease_age[i] + 16'd1;
                hit = -1;
                r.granted = 1'b1;
            end
            REQ_SWEEP: begin
                for (i = 0; i < TABLE_ENTRIES; i++)
                    if (lease_valid[i] && lease_age[i] > age_limit)
                        lease_valid[i] = 1'b0;
                hit = -1;
                r.granted = 1'b1;
            end
            REQ_CLEAR: begin
                for (i = 0; i < TABLE_ENTRIES; i++)
                    lease_valid[i] = 1'b0;
                hit = -1;
                r.granted = 1'b1;
            end
        endcase
        if (hit >= 0) begin
            r.owner      = lease_owner[hit];
            r.holds_lock = (lease_owner[hit] == rq.client_id);
            r.dirty      = lease_dirty[hit];
            r.version    = lease_ver[hit];
        end
        return r;
    endfunction

    function automatic void compare_field(input string field, input logic [31:0] want,
                                          input logic [31:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", field, want, got);
            fail_count++;
        end
    endfunction

    // Request driver: holds an item until it is taken, then waits its drawn gap.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid     <= 1'b0;
            req_if.req_type  <= REQ_ACQUIRE;
            req_if.client_id <= 16'd0;
            req_if.sector_x  <= 16'd0;
            req_if.sector_y  <= 16'd0;
        end else if (!req_if.valid || req_taken) begin
            if (req_gap > 0) begin
                req_if.valid <= 1'b0;
                req_gap = req_gap - 1;
            end else if (pending_reqs.size() != 0) begin
                drive_item = pending_reqs.pop_front();
                req_if.valid     <= 1'b1;
                req_if.req_type  <= drive_item.req_type;
                req_if.client_id <= drive_item.client_id;
                req_if.sector_x  <= drive_item.sector_x;
                req_if.sector_y  <= drive_item.sector_y;
                req_gap = quiet ? 0 : $urandom_range(0, 3);
            end else begin
                req_if.valid <= 1'b0;
            end
        end
    end

    // Result acceptor: after each transaction it draws a stall before taking the next.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
        end else begin
            if (rsp_taken)
                rsp_stall = quiet ? 0 : $urandom_range(0, 3);
            if (rsp_stall > 0) begin
                rsp_if.ready <= 1'b0;
                rsp_stall = rsp_stall - 1;
            end else begin
                rsp_if.ready <= 1'b1;
            end
        end
    end

    // Monitor: checks each result against the oldest prediction, predicts each new request.
    always @(posedge i_clk) begin
        req_taken <= i_rst_n && req_if.valid && req_if.ready;
        rsp_taken <= i_rst_n && rsp_if.valid && rsp_if.ready;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (expected_results.size() == 0) begin
                $error("Result transaction with no request outstanding");
                fail_count++;
            end else begin
                oldest_result = expected_results.pop_front();
                compare_field("granted", oldest_result.granted, rsp_if.granted);
                compare_field("owner", oldest_result.owner, rsp_if.owner);
                compare_field("holds_lock", oldest_result.holds_lock, rsp_if.holds_lock);
                compare_field("dirty", oldest_result.dirty, rsp_if.dirty);
                compare_field("version", oldest_result.version, rsp_if.version);
                compare_field("status", oldest_result.status, rsp_if.status);
            end
        end
        if (i_rst_n && req_if.valid && req_if.ready) begin
            oldest_result = lease_table_apply('{req_type:  t_req_type'(req_if.req_type),
                                                client_id: req_if.client_id,
                                                sector_x:  req_if.sector_x,
                                                sector_y:  req_if.sector_y});
            expected_results.push_back(oldest_result);
            req_count++;
            if (oldest_result.granted)
                granted_count++;
            if (oldest_result.status == STAT_LOCKED)
                locked_count++;
            if (oldest_result.status == STAT_FULL)
                full_count++;
        end
    end

    task automatic queue_req(input t_req_type op, input logic [15:0] cid,
                             input logic [15:0] sx, input logic [15:0] sy);
        pending_reqs.push_back('{req_type: op, client_id: cid, sector_x: sx, sector_y: sy});
    endtask

    task automatic write_max_age(input logic [15:0] value);
        @(negedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= value;
        do @(posedge i_clk); while (!cfg_if.ready);
        age_limit = value;
        setting_count++;
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic wait_drained();
        do @(posedge i_clk);
        while (pending_reqs.size() != 0 || req_if.valid || expected_results.size() != 0);
    endtask

    // More keys than table entries so that the table fills up now and then.
    function automatic void make_pools();
        int k;
        pool_x[0] = 16'h0000; pool_y[0] = 16'h0000;
        pool_x[1] = 16'hFFFF; pool_y[1] = 16'hFFFF;
        pool_x[2] = 16'h0000; pool_y[2] = 16'hFFFF;
        pool_x[3] = 16'hFFFF; pool_y[3] = 16'h0000;
        for (k = 4; k < KEY_POOL; k++) begin
            pool_x[k] = 16'($urandom_range(0, 16'hFFFF));
            pool_y[k] = 16'($urandom_range(0, 16'hFFFF));
        end
        // Some keys share a coordinate so that only the other one tells them apart.
        for (k = 8; k < 12; k++)
            pool_y[k] = pool_y[k - 4];
        for (k = 12; k < 14; k++)
            pool_x[k] = pool_x[k - 8];
        pool_client[0] = 16'h0000;
        pool_client[1] = 16'hFFFF;
        pool_client[2] = 16'h0001;
        for (k = 3; k < CLIENT_POOL; k++)
            pool_client[k] = 16'($urandom_range(0, 16'hFFFF));
    endfunction

    function automatic t_req random_request();
        t_req rq;
        int   k;
        int   pick;
        k = $urandom_range(0, KEY_POOL - 1);
        rq.sector_x = pool_x[k];
        rq.sector_y = pool_y[k];
        // Each key mostly sees one client, so releases by the owner are common.
        if ($urandom_range(0, 99) < 65)
            rq.client_id = pool_client[k % CLIENT_POOL];
        else
            rq.client_id = pool_client[$urandom_range(0, CLIENT_POOL - 1)];
        pick = $urandom_range(0, 99);
        if (pick < 26)
            rq.req_type = REQ_ACQUIRE;
        else if (pick < 40)
            rq.req_type = REQ_RELEASE;
        else if (pick < 50)
            rq.req_type = REQ_DIRTY;
        else if (pick < 62)
            rq.req_type = REQ_BUMP;
        else if (pick < 74)
            rq.req_type = REQ_QUERY;
        else if (pick < 88)
            rq.req_type = REQ_TICK;
        else if (pick < 97)
            rq.req_type = REQ_SWEEP;
        else
            rq.req_type = REQ_CLEAR;
        if ($urandom_range(0, 9) == 0) begin
            rq.req_type  = t_req_type'(3'($urandom_range(0, 7)));
            rq.client_id = 16'($urandom_range(0, 16'hFFFF));
            rq.sector_x  = 16'($urandom_range(0, 16'hFFFF));
            rq.sector_y  = 16'($urandom_range(0, 16'hFFFF));
        end
        return rq;
    endfunction

    initial begin
        logic [15:0] phase_limits [RANDOM_PHASES];
        int          p;
        int          n;
        i_rst_n          = 1'b0;
        cfg_if.valid     = 1'b0;
        cfg_if.data      = 16'd0;
        for (n = 0; n < TABLE_ENTRIES; n++)
            lease_valid[n] = 1'b0;
        age_limit = MAX_AGE_RESET;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed requests under the reset value of max_age.
        queue_req(REQ_ACQUIRE, 16'd5, 16'd1, 16'd1);
        queue_req(REQ_ACQUIRE, 16'd5, 16'd1, 16'd1);
        queue_req(REQ_ACQUIRE, 16'd7, 16'd1, 16'd1);
        queue_req(REQ_QUERY, 16'd7, 16'd1, 16'd1);
        queue_req(REQ_DIRTY, 16'd0, 16'd1, 16'd1);
        queue_req(REQ_BUMP, 16'd5, 16'd1, 16'd1);
        queue_req(REQ_BUMP, 16'd3, 16'd2, 16'd2);
        queue_req(REQ_ACQUIRE, 16'd0, 16'd2, 16'd2);
        queue_req(REQ_RELEASE, 16'd0, 16'd2, 16'd2);
        queue_req(REQ_RELEASE, 16'd7, 16'd1, 16'd1);
        queue_req(REQ_RELEASE, 16'd5, 16'd9, 16'd9);
        queue_req(REQ_DIRTY, 16'd5, 16'd9, 16'd9);
        queue_req(REQ_QUERY, 16'd5, 16'd9, 16'd9);
        queue_req(REQ_ACQUIRE, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        queue_req(REQ_ACQUIRE, 16'd0, 16'd0, 16'd0);
        queue_req(REQ_ACQUIRE, 16'd1, 16'hFFFF, 16'd0);
        queue_req(REQ_ACQUIRE, 16'd1, 16'd0, 16'hFFFF);
        queue_req(REQ_TICK, 16'hA5A5, 16'h5A5A, 16'hFFFF);
        queue_req(REQ_SWEEP, 16'hFFFF, 16'd1, 16'd1);
        queue_req(REQ_QUERY, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        queue_req(REQ_CLEAR, 16'd5, 16'd1, 16'd1);
        queue_req(REQ_QUERY, 16'd5, 16'd1, 16'd1);
        wait_drained();

        phase_limits = '{16'd0, 16'd2, 16'd30, 16'hFFFF, 16'd0, 16'd1};
        phase_limits[4] = 16'($urandom_range(3, 400));
        for (p = 0; p < RANDOM_PHASES; p++) begin
            write_max_age(phase_limits[p]);
            quiet = (p == 2);
            make_pools();
            for (n = 0; n < PHASE_ITEMS; n++)
                pending_reqs.push_back(random_request());
            wait_drained();
        end

        repeat (TABLE_ENTRIES + 4) @(posedge i_clk);
        $display("Checked %0d directed and random requests over %0d max_age settings:",
                 req_count, setting_count);
        $display("%0d granted, %0d refused as locked, %0d refused as table full.",
                 granted_count, locked_count, full_count);
        if (fail_count == 0 && expected_results.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
